// ===== hdl/fbpbw_pkg.sv =====
// fbpbw_pkg: shared types, constants and codes for the framebuffer pixel blend writer
// used by fbpbw_ctrl, fbpbw_datapath and framebuffer_pixel_blend_writer_core
`timescale 1ns / 1ps

package fbpbw_pkg;

    // frame store geometry
    localparam int STORE_WORDS = 4096;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    // field widths
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 7;
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int SUM_W      = PROD_W;
    localparam int STORE_CW   = $clog2(STORE_WORDS + 1);
    localparam int CMP_W      = (SUM_W > STORE_CW) ? SUM_W : STORE_CW;
    localparam int MIX_W      = 2 * CHAN_W;
    localparam int NUM_CHAN   = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_WORDS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ENABLE = 2'd3;

    localparam logic [DIM_W-1:0] RST_FB_WIDTH    = 7'd64;
    localparam logic [DIM_W-1:0] RST_FB_HEIGHT   = 7'd64;
    localparam logic [DIM_W-1:0] RST_PITCH_WORDS = 7'd64;

    // operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // alpha special values
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] read_data;
        logic             in_bounds;
    } t_out_word;

    typedef struct packed {
        logic [DIM_W-1:0] fb_width;
        logic [DIM_W-1:0] fb_height;
        logic [DIM_W-1:0] pitch_words;
        logic             blend_enable;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load_in;
        logic mul;
        logic addr;
        logic rd;
        logic mix;
        logic sum;
        logic wr;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic ok;
        logic is_read;
        logic blend;
        logic out_free;
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_ROUTE,
        ST_MIX,
        ST_SUM,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

// ===== hdl/fbpbw_ctrl.sv =====
// fbpbw_ctrl: sequencer for the pixel port, issues datapath commands per state
// depends on fbpbw_pkg
`timescale 1ns / 1ps

module fbpbw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbpbw_pkg::t_status i_status,
    output fbpbw_pkg::t_cmd    o_cmd
);

    fbpbw_pkg::t_state r_state;
    fbpbw_pkg::t_state n_state;

    // state register, reset starts the store clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpbw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fbpbw_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = fbpbw_pkg::ST_IDLE;
                end
            end
            fbpbw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = fbpbw_pkg::ST_MUL;
                end
            end
            fbpbw_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = fbpbw_pkg::ST_ADDR;
            end
            fbpbw_pkg::ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = fbpbw_pkg::ST_ROUTE;
            end
            // pick the access path once bounds are known
            fbpbw_pkg::ST_ROUTE: begin
                if (!i_status.ok) begin
                    n_state = fbpbw_pkg::ST_DONE;
                end else if (i_status.is_read) begin
                    o_cmd.rd = 1'b1;
                    n_state  = fbpbw_pkg::ST_DONE;
                end else if (i_status.blend) begin
                    o_cmd.rd = 1'b1;
                    n_state  = fbpbw_pkg::ST_MIX;
                end else begin
                    n_state = fbpbw_pkg::ST_WRITE;
                end
            end
            fbpbw_pkg::ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = fbpbw_pkg::ST_SUM;
            end
            fbpbw_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = fbpbw_pkg::ST_WRITE;
            end
            fbpbw_pkg::ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = fbpbw_pkg::ST_DONE;
            end
            // hand the result to the output register when it has room
            fbpbw_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fbpbw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbpbw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fbpbw_datapath.sv =====
// fbpbw_datapath: address arithmetic, frame store, blend lanes and output register
// depends on fbpbw_pkg
`timescale 1ns / 1ps

module fbpbw_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fbpbw_pkg::t_in_word  i_in_data,
    input  fbpbw_pkg::t_cfg      i_cfg,
    input  fbpbw_pkg::t_cmd      i_cmd,
    output fbpbw_pkg::t_status   o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fbpbw_pkg::t_out_word o_out_data
);

    fbpbw_pkg::t_in_word                  r_in;
    logic                                 r_inb;
    logic [fbpbw_pkg::PROD_W-1:0]         r_prod;
    logic [fbpbw_pkg::CMP_W-1:0]          r_sum;
    logic                                 r_ok;
    logic [fbpbw_pkg::PIX_W-1:0]          r_wdata;
    logic [fbpbw_pkg::PIX_W-1:0]          r_rd_data;
    logic [fbpbw_pkg::MIX_W-1:0]          r_ps [fbpbw_pkg::NUM_CHAN];
    logic [fbpbw_pkg::MIX_W-1:0]          r_pd [fbpbw_pkg::NUM_CHAN];
    logic [fbpbw_pkg::ADDR_W-1:0]         r_clr_cnt;
    logic [fbpbw_pkg::PIX_W-1:0]          r_mem [fbpbw_pkg::STORE_WORDS];
    fbpbw_pkg::t_out_word                 r_out;
    logic                                 r_out_valid;

    logic [fbpbw_pkg::CMP_W-1:0]          n_sum;
    logic [fbpbw_pkg::ADDR_W-1:0]         addr;
    logic [fbpbw_pkg::CHAN_W-1:0]         alpha;
    logic [fbpbw_pkg::CHAN_W-1:0]         alpha_inv;
    logic [fbpbw_pkg::PIX_W-1:0]          n_blend;
    logic [fbpbw_pkg::MIX_W:0]            chan_sum [fbpbw_pkg::NUM_CHAN];

    assign addr      = r_sum[fbpbw_pkg::ADDR_W-1:0];
    assign alpha     = r_in.pixel[fbpbw_pkg::PIX_W-1 -: fbpbw_pkg::CHAN_W];
    assign alpha_inv = fbpbw_pkg::ALPHA_OPAQUE - alpha;
    assign n_sum     = fbpbw_pkg::CMP_W'(r_prod)
                     + fbpbw_pkg::CMP_W'(r_in.x[fbpbw_pkg::DIM_W-1:0]);

    // item capture, bounds, address and write data
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in    <= i_in_data;
            r_wdata <= i_in_data.pixel;
        end
        if (i_cmd.mul) begin
            r_inb  <= (r_in.x < fbpbw_pkg::COORD_W'(i_cfg.fb_width))
                   && (r_in.y < fbpbw_pkg::COORD_W'(i_cfg.fb_height));
            r_prod <= fbpbw_pkg::PROD_W'(r_in.y[fbpbw_pkg::DIM_W-1:0])
                    * fbpbw_pkg::PROD_W'(i_cfg.pitch_words);
        end
        if (i_cmd.addr) begin
            r_sum <= n_sum;
            r_ok  <= r_inb && (n_sum < fbpbw_pkg::CMP_W'(fbpbw_pkg::STORE_WORDS));
        end
        if (i_cmd.sum) begin
            r_wdata <= n_blend;
        end
    end

    // blend products, one lane per colour channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            for (int c = 0; c < fbpbw_pkg::NUM_CHAN; c++) begin
                r_ps[c] <= fbpbw_pkg::MIX_W'(r_in.pixel[c*fbpbw_pkg::CHAN_W +: fbpbw_pkg::CHAN_W])
                         * fbpbw_pkg::MIX_W'(alpha);
                r_pd[c] <= fbpbw_pkg::MIX_W'(r_rd_data[c*fbpbw_pkg::CHAN_W +: fbpbw_pkg::CHAN_W])
                         * fbpbw_pkg::MIX_W'(alpha_inv);
            end
        end
    end

    // channel sums with rounding, then source-over select
    always_comb begin
        for (int c = 0; c < fbpbw_pkg::NUM_CHAN; c++) begin
            chan_sum[c] = {1'b0, r_ps[c]} + {1'b0, r_pd[c]}
                        + (fbpbw_pkg::MIX_W+1)'(fbpbw_pkg::ALPHA_OPAQUE);
        end
        if (alpha == fbpbw_pkg::ALPHA_OPAQUE) begin
            n_blend = r_in.pixel;
        end else if (alpha == fbpbw_pkg::ALPHA_CLEAR) begin
            n_blend = r_rd_data;
        end else begin
            n_blend = {fbpbw_pkg::ALPHA_OPAQUE,
                       chan_sum[2][fbpbw_pkg::MIX_W-1:fbpbw_pkg::CHAN_W],
                       chan_sum[1][fbpbw_pkg::MIX_W-1:fbpbw_pkg::CHAN_W],
                       chan_sum[0][fbpbw_pkg::MIX_W-1:fbpbw_pkg::CHAN_W]};
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + fbpbw_pkg::ADDR_W'(1);
        end
    end

    // frame store, one port shared by clear, read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[addr] <= r_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.read_data <= (r_ok && r_in.func == fbpbw_pkg::FUNC_READ) ? r_rd_data : '0;
            r_out.in_bounds <= r_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status back to the controller
    always_comb begin
        o_status.clr_last = (r_clr_cnt == fbpbw_pkg::ADDR_W'(fbpbw_pkg::STORE_WORDS - 1));
        o_status.ok       = r_ok;
        o_status.is_read  = (r_in.func == fbpbw_pkg::FUNC_READ);
        o_status.blend    = i_cfg.blend_enable;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

endmodule

// ===== hdl/framebuffer_pixel_blend_writer_core.sv =====
// framebuffer_pixel_blend_writer_core: top level, configuration registers and wiring
// depends on fbpbw_pkg, fbpbw_ctrl, fbpbw_datapath
//
//   channel  direction  handshake               payload
//   in       into core  i_in_valid/o_in_ready   i_in_data  (func, x, y, pixel)
//   out      from core  o_out_valid/i_out_ready o_out_data (read_data, in_bounds)
//   cfg      into core  i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// one word is worked on at a time: it passes ST_MUL, ST_ADDR and ST_ROUTE, then
// a read or a dropped access goes to ST_DONE, a plain write through ST_WRITE and
// a blended write through ST_MIX, ST_SUM and ST_WRITE on the single store port.
// after reset a clearing pass zeroes the whole store, one word a cycle,
// with o_in_ready low; configuration writes are taken throughout.
// a stalled output holds its word while the next input is already accepted.
`timescale 1ns / 1ps

module framebuffer_pixel_blend_writer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fbpbw_pkg::t_in_word                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fbpbw_pkg::t_out_word                o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [fbpbw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fbpbw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    fbpbw_pkg::t_cfg    r_cfg;
    fbpbw_pkg::t_cmd    cmd;
    fbpbw_pkg::t_status status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fb_width     <= fbpbw_pkg::RST_FB_WIDTH;
            r_cfg.fb_height    <= fbpbw_pkg::RST_FB_HEIGHT;
            r_cfg.pitch_words  <= fbpbw_pkg::RST_PITCH_WORDS;
            r_cfg.blend_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fbpbw_pkg::CFG_FB_WIDTH:     r_cfg.fb_width     <= i_cfg_data;
                fbpbw_pkg::CFG_FB_HEIGHT:    r_cfg.fb_height    <= i_cfg_data;
                fbpbw_pkg::CFG_PITCH_WORDS:  r_cfg.pitch_words  <= i_cfg_data;
                fbpbw_pkg::CFG_BLEND_ENABLE: r_cfg.blend_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    fbpbw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath with frame store
    fbpbw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/framebuffer_pixel_blend_writer_core_tb.sv =====
// framebuffer_pixel_blend_writer_core_tb: checks pixel reads, plain and blended writes and
// bounds handling against a shadow frame store, under random sender and receiver idling
// depends on fbpbw_pkg and framebuffer_pixel_blend_writer_core
`timescale 1ns / 1ps

module framebuffer_pixel_blend_writer_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 16;

    // clock, reset and block inputs, all known from time zero
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    fbpbw_pkg::t_in_word              in_data   = '0;
    logic                             out_ready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [fbpbw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fbpbw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                             o_in_ready;
    logic                             o_out_valid;
    fbpbw_pkg::t_out_word             o_out_data;

    // shadow of the block's state and registers
    logic [fbpbw_pkg::PIX_W-1:0] shadow_frame [fbpbw_pkg::STORE_WORDS];
    fbpbw_pkg::t_cfg             shadow_cfg;

    // words waiting to be sent and results waiting to arrive
    fbpbw_pkg::t_in_word         pending_words [$];
    fbpbw_pkg::t_out_word        expected_words [$];
    logic [23:0]                 recent_coords [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int rx_mode        = 0;
    int rx_mode_left   = 0;

    framebuffer_pixel_blend_writer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // source-over mix of one pixel onto the stored one
    function automatic logic [fbpbw_pkg::PIX_W-1:0] blend_source_over(
            input logic [fbpbw_pkg::PIX_W-1:0] dst,
            input logic [fbpbw_pkg::PIX_W-1:0] src);
        logic [fbpbw_pkg::PIX_W-1:0] mixed;
        int unsigned                 a;
        int unsigned                 s;
        int unsigned                 d;
        int unsigned                 chan;
        a = 32'(src[31:24]);
        if (src[31:24] == fbpbw_pkg::ALPHA_OPAQUE) return src;
        if (src[31:24] == fbpbw_pkg::ALPHA_CLEAR) return dst;
        mixed[31:24] = 8'hFF;
        for (int c = 0; c < fbpbw_pkg::NUM_CHAN; c++) begin
            s    = 32'(src[8*c +: 8]);
            d    = 32'(dst[8*c +: 8]);
            chan = (s * a + d * (255 - a) + 255) >> 8;
            mixed[8*c +: 8] = chan[7:0];
        end
        return mixed;
    endfunction

    // apply one access to the shadow store and return the word it should produce
    function automatic fbpbw_pkg::t_out_word predict_access(input fbpbw_pkg::t_in_word w);
        fbpbw_pkg::t_out_word r;
        int unsigned          addr;
        r = '0;
        if (w.x < fbpbw_pkg::COORD_W'(shadow_cfg.fb_width)
                && w.y < fbpbw_pkg::COORD_W'(shadow_cfg.fb_height)) begin
            addr = 32'(w.y) * 32'(shadow_cfg.pitch_words) + 32'(w.x);
            if (addr < fbpbw_pkg::STORE_WORDS) begin
                r.in_bounds = 1'b1;
                if (w.func == fbpbw_pkg::FUNC_READ)
                    r.read_data = shadow_frame[addr];
                else if (shadow_cfg.blend_enable)
                    shadow_frame[addr] = blend_source_over(shadow_frame[addr], w.pixel);
                else
                    shadow_frame[addr] = w.pixel;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [fbpbw_pkg::PIX_W-1:0] want,
                                 input logic [fbpbw_pkg::PIX_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    endtask

    task automatic queue_access(input logic func, input int unsigned x, input int unsigned y,
                                input logic [fbpbw_pkg::PIX_W-1:0] pixel);
        fbpbw_pkg::t_in_word w;
        w.func  = func;
        w.x     = x[fbpbw_pkg::COORD_W-1:0];
        w.y     = y[fbpbw_pkg::COORD_W-1:0];
        w.pixel = pixel;
        pending_words.push_back(w);
    endtask

    // wait until nothing is in flight, then let the block settle
    task automatic drain;
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fbpbw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbpbw_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fbpbw_pkg::CFG_FB_WIDTH:     shadow_cfg.fb_width     = val;
            fbpbw_pkg::CFG_FB_HEIGHT:    shadow_cfg.fb_height    = val;
            fbpbw_pkg::CFG_PITCH_WORDS:  shadow_cfg.pitch_words  = val;
            fbpbw_pkg::CFG_BLEND_ENABLE: shadow_cfg.blend_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned p,
                                input logic [fbpbw_pkg::CFG_DATA_W-1:0] blend);
        drain();
        write_reg(fbpbw_pkg::CFG_FB_WIDTH, w[fbpbw_pkg::CFG_DATA_W-1:0]);
        write_reg(fbpbw_pkg::CFG_FB_HEIGHT, h[fbpbw_pkg::CFG_DATA_W-1:0]);
        write_reg(fbpbw_pkg::CFG_PITCH_WORDS, p[fbpbw_pkg::CFG_DATA_W-1:0]);
        write_reg(fbpbw_pkg::CFG_BLEND_ENABLE, blend);
        recent_coords.delete();
    endtask

    // mostly inside the visible range, some at its edge, some anywhere
    function automatic logic [fbpbw_pkg::COORD_W-1:0] pick_coord(input int unsigned lim);
        int unsigned                   sel;
        logic [fbpbw_pkg::COORD_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 75)
            v = (lim == 0) ? '0 : fbpbw_pkg::COORD_W'($urandom_range(lim - 1));
        else if (sel < 90)
            v = fbpbw_pkg::COORD_W'($urandom_range(lim + 2, (lim > 2) ? lim - 2 : 0));
        else
            v = fbpbw_pkg::COORD_W'($urandom);
        return v;
    endfunction

    // alpha leans on the opaque, clear and near-edge values
    function automatic logic [fbpbw_pkg::PIX_W-1:0] pick_pixel;
        logic [fbpbw_pkg::PIX_W-1:0] p;
        p = $urandom;
        case ($urandom_range(7))
            0: p[31:24] = fbpbw_pkg::ALPHA_CLEAR;
            1: p[31:24] = fbpbw_pkg::ALPHA_OPAQUE;
            2: p[31:24] = 8'h01;
            3: p[31:24] = 8'hFE;
            default: ;
        endcase
        return p;
    endfunction

    task automatic queue_random_pixels(input int n);
        fbpbw_pkg::t_in_word w;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 35 && recent_coords.size() != 0)
                {w.x, w.y} = recent_coords[$urandom_range(recent_coords.size() - 1)];
            else begin
                w.x = pick_coord(32'(shadow_cfg.fb_width));
                w.y = pick_coord(32'(shadow_cfg.fb_height));
            end
            w.func  = ($urandom_range(99) < 45) ? fbpbw_pkg::FUNC_READ : fbpbw_pkg::FUNC_WRITE;
            w.pixel = pick_pixel();
            pending_words.push_back(w);
            if (w.func == fbpbw_pkg::FUNC_WRITE) begin
                recent_coords.push_back({w.x, w.y});
                if (recent_coords.size() > 16) void'(recent_coords.pop_front());
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                in_data  <= pending_words.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(4) == 0) ? $urandom_range(120, 40)
                                                           : $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: switches between always ready, coin flip and long stalls
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(2);
            rx_mode_left <= $urandom_range(200, 20);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(1);
            default: out_ready <= ($urandom_range(15) == 0);
        endcase
    end

    // compare each delivered word with the oldest expectation, predict each accepted one
    always @(posedge clk) begin
        fbpbw_pkg::t_out_word want;
        if (rst_n) begin
            if (o_out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch("unexpected word", '0, o_out_data.read_data);
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_data.read_data !== want.read_data)
                        flag_mismatch("read_data", want.read_data, o_out_data.read_data);
                    if (o_out_data.in_bounds !== want.in_bounds)
                        flag_mismatch("in_bounds", fbpbw_pkg::PIX_W'(want.in_bounds),
                                      fbpbw_pkg::PIX_W'(o_out_data.in_bounds));
                end
            end
            if (in_valid && o_in_ready)
                expected_words.push_back(predict_access(in_data));
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("** framebuffer_pixel_blend_writer_core: FAILED **");
            $finish;
        end
    end

    // reset, directed accesses, then random phases over several geometries
    initial begin
        for (int i = 0; i < fbpbw_pkg::STORE_WORDS; i++) shadow_frame[i] = '0;
        shadow_cfg.fb_width     = fbpbw_pkg::RST_FB_WIDTH;
        shadow_cfg.fb_height    = fbpbw_pkg::RST_FB_HEIGHT;
        shadow_cfg.pitch_words  = fbpbw_pkg::RST_PITCH_WORDS;
        shadow_cfg.blend_enable = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: cleared store, plain writes, coordinates outside
        queue_access(fbpbw_pkg::FUNC_READ, 0, 0, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_WRITE, 0, 0, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_READ, 0, 0, 32'h0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 63, 63, 32'h1234_5678);
        queue_access(fbpbw_pkg::FUNC_READ, 63, 63, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_WRITE, 64, 5, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_READ, 5, 64, 32'h0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 4095, 4095, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_READ, 4095, 4095, 32'h0);

        // blending: half alpha, clear, opaque, near-edge alphas, back-to-back same address
        set_geometry(64, 64, 64, 1);
        queue_access(fbpbw_pkg::FUNC_WRITE, 0, 0, 32'h8010_2030);
        queue_access(fbpbw_pkg::FUNC_WRITE, 0, 0, 32'h00AB_CDEF);
        queue_access(fbpbw_pkg::FUNC_READ, 0, 0, 32'h0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 1, 0, 32'hFF00_FF00);
        queue_access(fbpbw_pkg::FUNC_WRITE, 1, 0, 32'h7F00_00FF);
        queue_access(fbpbw_pkg::FUNC_READ, 1, 0, 32'h0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 2, 0, 32'h01FF_FFFF);
        queue_access(fbpbw_pkg::FUNC_WRITE, 2, 0, 32'hFE00_0000);
        queue_access(fbpbw_pkg::FUNC_READ, 2, 0, 32'h0);

        // widest geometry: last word of the store and the first address past it
        set_geometry(127, 127, 127, 7'h7F);
        queue_access(fbpbw_pkg::FUNC_WRITE, 31, 32, 32'hFF55_AA55);
        queue_access(fbpbw_pkg::FUNC_READ, 31, 32, 32'h0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 32, 32, 32'hFFFF_FFFF);
        queue_access(fbpbw_pkg::FUNC_READ, 127, 127, 32'h0);

        // zero pitch folds every row onto the first
        set_geometry(64, 64, 0, 7'h7E);
        queue_access(fbpbw_pkg::FUNC_WRITE, 5, 10, 32'h1357_9BDF);
        queue_access(fbpbw_pkg::FUNC_READ, 5, 63, 32'h0);

        // zero width, then zero height
        set_geometry(0, 64, 64, 0);
        queue_access(fbpbw_pkg::FUNC_READ, 0, 0, 32'h0);
        set_geometry(64, 0, 64, 0);
        queue_access(fbpbw_pkg::FUNC_WRITE, 0, 0, 32'hFFFF_FFFF);

        // random phases
        set_geometry(64, 64, 64, 0);
        queue_random_pixels(100);
        set_geometry(64, 64, 64, 1);
        queue_random_pixels(100);
        drain();
        queue_random_pixels(100);
        set_geometry(127, 127, 127, 1);
        queue_random_pixels(150);
        set_geometry(16, 16, 16, 1);
        queue_random_pixels(150);
        set_geometry(32, 32, 0, 1);
        queue_random_pixels(100);
        set_geometry($urandom_range(127), $urandom_range(127), $urandom_range(127),
                     fbpbw_pkg::CFG_DATA_W'($urandom_range(1)));
        queue_random_pixels(150);
        set_geometry(1, 1, 1, 0);
        queue_random_pixels(30);
        set_geometry(40, 64, 100, 1);
        queue_random_pixels(120);
        set_geometry(64, 64, 64, 0);
        queue_random_pixels(100);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("** framebuffer_pixel_blend_writer_core: PASSED **");
        else
            $display("** framebuffer_pixel_blend_writer_core: FAILED **");
        $finish;
    end

endmodule

// ===== framebuffer_pixel_blend_writer_core.f =====
hdl/fbpbw_pkg.sv
hdl/fbpbw_ctrl.sv
hdl/fbpbw_datapath.sv
hdl/framebuffer_pixel_blend_writer_core.sv
bench/framebuffer_pixel_blend_writer_core_tb.sv
